[hdl/bst_pkg.sv]
// bst_pkg: shared types and constants of the bezier stroke tessellator
// no dependencies; imported by every module of the block
`default_nettype none

package bst_pkg;

  localparam int MAX_SEGMENTS = 31;
  localparam int SEG_W = 5;
  localparam int CW = 34;
  localparam int DVW = 52;
  localparam int DSW = 25;
  localparam int CNT_W = 6;

  localparam logic [1:0] REG_STROKE_WIDTH = 2'd0;
  localparam logic [1:0] REG_SEGMENT_COUNT = 2'd1;
  localparam logic [1:0] REG_START_COLOR = 2'd2;
  localparam logic [1:0] REG_END_COLOR = 2'd3;

  typedef struct packed {
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic signed [15:0] bend;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [SEG_W-1:0] step_index;
    logic side;
    logic last;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } job_t;

  typedef struct packed {
    logic start;
    logic [DVW-1:0] dividend;
    logic [CNT_W-1:0] count;
    logic [DSW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DVW-1:0] quot;
    logic [DSW-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

[hdl/bst_div.sv]
// bst_div: restoring divider, one quotient bit per cycle
// depends on bst_pkg; dividend arrives msb aligned with its bit count
`default_nettype none

module bst_div import bst_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic busy_r;
  logic done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVW-1:0] dvd_r;
  logic [DVW-1:0] quo_r;
  logic [DSW-1:0] rem_r;
  logic [DSW-1:0] dvs_r;
  logic [DSW:0] rem2;
  logic [DSW:0] diff;
  logic ge;

  always_comb begin
    rem2 = {rem_r, dvd_r[DVW-1]};
    ge = rem2 >= {1'b0, dvs_r};
    diff = rem2 - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        dvd_r <= req.dividend;
        quo_r <= '0;
        rem_r <= '0;
        dvs_r <= req.divisor;
        cnt_r <= req.count;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DSW-1:0] : rem2[DSW-1:0];
        quo_r <= {quo_r[DVW-2:0], ge};
        dvd_r <= {dvd_r[DVW-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem = rem_r;

endmodule

`default_nettype wire

[hdl/bst_front.sv]
// bst_front: accepts curve requests and forms the control point
// depends on bst_pkg; feeds bst_queue
`default_nettype none

module bst_front import bst_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire in_item_t item,
  output logic          busy,
  input  wire logic     q_full,
  output logic          push,
  output job_t          job
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0] st_r;
  in_item_t in_r;
  logic signed [32:0] pdx_r;
  logic signed [32:0] pdy_r;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [16:0] sum_x;
  logic signed [16:0] sum_y;

  always_comb begin
    dx = 17'(in_r.end_x) - 17'(in_r.start_x);
    dy = 17'(in_r.end_y) - 17'(in_r.start_y);
    sum_x = 17'(in_r.end_x) + 17'(in_r.start_x);
    sum_y = 17'(in_r.end_y) + 17'(in_r.start_y);
    job.sx = in_r.start_x;
    job.sy = in_r.start_y;
    job.ex = in_r.end_x;
    job.ey = in_r.end_y;
    job.cx = (CW'(sum_x) <<< 11) - CW'(pdy_r);
    job.cy = (CW'(sum_y) <<< 11) + CW'(pdx_r);
    push = (st_r == F_PUSH) && !q_full;
    busy = st_r != F_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      unique case (st_r)
        F_IDLE: begin
          if (start) begin
            in_r <= item;
            st_r <= F_MUL;
          end
        end
        F_MUL: begin
          pdx_r <= dx * in_r.bend;
          pdy_r <= dy * in_r.bend;
          st_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            st_r <= F_IDLE;
          end
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/bst_queue.sv]
// bst_queue: two-entry queue of prepared curve jobs
// depends on bst_pkg; sits between bst_front and bst_back
`default_nettype none

module bst_queue import bst_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t wdata,
  input  wire logic pop,
  output job_t      rdata,
  output logic      empty,
  output logic      full
);

  job_t mem_r [2];
  logic wr_ptr_r;
  logic rd_ptr_r;
  logic [1:0] cnt_r;

  assign rdata = mem_r[rd_ptr_r];
  assign empty = cnt_r == 2'd0;
  assign full = cnt_r == 2'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= wdata;
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

[hdl/bst_back.sv]
// bst_back: steps along the curve and emits two strip vertices per step
// depends on bst_pkg; takes jobs from bst_queue, uses bst_div
`default_nettype none

module bst_back import bst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [15:0] stroke_width,
  input  wire logic [SEG_W-1:0] segment_count,
  input  wire logic [31:0] start_color,
  input  wire logic [31:0] end_color,
  input  wire logic        q_empty,
  input  wire job_t        q_data,
  output logic             q_pop,
  output div_req_t         div_req,
  input  wire div_rsp_t    div_rsp,
  output logic             out_valid,
  output out_item_t        out_item
);

  localparam int AW = 48;
  localparam int DW = 35;
  localparam int TW = 41;
  localparam int QW = 46;
  localparam int OW = 29;
  localparam int VW = 47;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_MAC = 4'd2;
  localparam logic [3:0] S_ABS = 4'd3;
  localparam logic [3:0] S_NORM = 4'd4;
  localparam logic [3:0] S_SQ0 = 4'd5;
  localparam logic [3:0] S_SQ1 = 4'd6;
  localparam logic [3:0] S_SQRT = 4'd7;
  localparam logic [3:0] S_LOAD = 4'd8;
  localparam logic [3:0] S_DIV = 4'd9;
  localparam logic [3:0] S_EMIT0 = 4'd10;
  localparam logic [3:0] S_EMIT1 = 4'd11;

  localparam logic [2:0] OP_MX = 3'd0;
  localparam logic [2:0] OP_MY = 3'd1;
  localparam logic [2:0] OP_PX = 3'd2;
  localparam logic [2:0] OP_PY = 3'd3;
  localparam logic [2:0] OP_C0 = 3'd4;
  localparam logic [2:0] OP_C1 = 3'd5;
  localparam logic [2:0] OP_C2 = 3'd6;
  localparam logic [2:0] OP_C3 = 3'd7;

  logic [3:0] st_r;
  job_t job_r;
  logic [SEG_W-1:0] n_r;
  logic [9:0] d_r;
  logic [SEG_W-1:0] i_r;
  logic [SEG_W-1:0] u_r;
  logic [9:0] uu_r;
  logic [9:0] ui2_r;
  logic [9:0] ii_r;
  logic [3:0] ph_r;
  logic signed [AW-1:0] px_r;
  logic signed [AW-1:0] py_r;
  logic signed [AW-1:0] tx_r;
  logic signed [AW-1:0] ty_r;
  logic [TW-1:0] ax_r;
  logic [TW-1:0] ay_r;
  logic [49:0] sqx_r;
  logic [49:0] sqr_r;
  logic [49:0] sqb_r;
  logic [4:0] scnt_r;
  logic [2:0] op_r;
  logic pneg_r;
  logic signed [OW-1:0] ox_r;
  logic signed [OW-1:0] oy_r;
  logic signed [QW-1:0] qx_r;
  logic signed [QW-1:0] qy_r;
  logic [7:0] col_r [4];
  logic [12:0] cnum_r [4];
  div_req_t div_req_r;
  logic out_valid_r;
  out_item_t out_r;

  logic [SEG_W-1:0] nsel;
  logic [SEG_W-1:0] u_c;
  logic [7:0] sc [4];
  logic [7:0] ec [4];
  logic signed [14:0] cn_c [4];
  logic signed [DW-1:0] s16x;
  logic signed [DW-1:0] s16y;
  logic signed [DW-1:0] e16x;
  logic signed [DW-1:0] e16y;
  logic signed [DW-1:0] cx35;
  logic signed [DW-1:0] cy35;
  logic [9:0] ma;
  logic signed [DW-1:0] mb;
  logic signed [45:0] prod_w;
  logic signed [AW-1:0] acc_old;
  logic signed [AW-1:0] acc_new;
  logic clr;
  logic signed [AW-1:0] tx_mag;
  logic signed [AW-1:0] ty_mag;
  logic [TW-1:0] mxv;
  logic [49:0] trial;
  logic [DSW-1:0] len;
  logic [26:0] wq;
  logic signed [AW-1:0] pa;
  logic signed [AW-1:0] pa_mag;
  logic [43:0] q44;
  logic signed [QW-1:0] qf;
  logic [27:0] mq;
  logic signed [VW-1:0] v0x;
  logic signed [VW-1:0] v0y;
  logic signed [VW-1:0] v1x;
  logic signed [VW-1:0] v1y;

  function automatic logic signed [15:0] sat16(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] sh;
    sh = v >>> 12;
    if (sh > VW'(32767)) begin
      sat16 = 16'sh7fff;
    end else if (sh < -VW'(32768)) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = sh[15:0];
    end
  endfunction

  always_comb begin
    nsel = (segment_count == '0) ? SEG_W'(1) : segment_count;
    u_c = n_r - i_r;
    for (int k = 0; k < 4; k++) begin
      sc[k] = start_color[8*(3-k) +: 8];
      ec[k] = end_color[8*(3-k) +: 8];
      cn_c[k] = 15'($signed({1'b0, sc[k]}) * $signed({1'b0, n_r}))
              + 15'($signed({1'b0, i_r}) * ($signed({1'b0, ec[k]}) - $signed({1'b0, sc[k]})));
    end
    s16x = DW'(job_r.sx) <<< 12;
    s16y = DW'(job_r.sy) <<< 12;
    e16x = DW'(job_r.ex) <<< 12;
    e16y = DW'(job_r.ey) <<< 12;
    cx35 = DW'(job_r.cx);
    cy35 = DW'(job_r.cy);
    clr = 1'b0;
    acc_old = px_r;
    case (ph_r)
      4'd0: begin ma = uu_r; mb = s16x; clr = 1'b1; end
      4'd1: begin ma = ui2_r; mb = cx35; end
      4'd2: begin ma = ii_r; mb = e16x; end
      4'd3: begin ma = uu_r; mb = s16y; clr = 1'b1; end
      4'd4: begin ma = ui2_r; mb = cy35; acc_old = py_r; end
      4'd5: begin ma = ii_r; mb = e16y; acc_old = py_r; end
      4'd6: begin ma = 10'(u_r); mb = cx35 - s16x; clr = 1'b1; end
      4'd7: begin ma = 10'(i_r); mb = e16x - cx35; acc_old = tx_r; end
      4'd8: begin ma = 10'(u_r); mb = cy35 - s16y; clr = 1'b1; end
      default: begin ma = 10'(i_r); mb = e16y - cy35; acc_old = ty_r; end
    endcase
    prod_w = $signed({1'b0, ma}) * mb;
    acc_new = clr ? AW'(prod_w) : acc_old + AW'(prod_w);
    tx_mag = tx_r[AW-1] ? -tx_r : tx_r;
    ty_mag = ty_r[AW-1] ? -ty_r : ty_r;
    mxv = (ax_r > ay_r) ? ax_r : ay_r;
    trial = sqr_r + sqb_r;
    len = sqr_r[DSW-1:0];
    wq = {stroke_width, 11'd0};
    pa = ((op_r == OP_PY) ? py_r : px_r) + AW'({d_r, 11'd0});
    pa_mag = pa[AW-1] ? -pa : pa;
    q44 = div_rsp.quot[43:0];
    qf = pneg_r ? -(QW'(q44) + QW'(div_rsp.rem != '0)) : QW'(q44);
    mq = div_rsp.quot[27:0];
    v0x = VW'(qx_r) - VW'(ox_r);
    v1x = VW'(qx_r) + VW'(ox_r);
    v0y = VW'(qy_r) - VW'(oy_r);
    v1y = VW'(qy_r) + VW'(oy_r);
    q_pop = (st_r == S_IDLE) && !q_empty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid_r <= 1'b0;
      div_req_r.start <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      div_req_r.start <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (!q_empty) begin
            job_r <= q_data;
            n_r <= nsel;
            d_r <= 10'(nsel * nsel);
            i_r <= '0;
            st_r <= S_PREP;
          end
        end
        S_PREP: begin
          u_r <= u_c;
          uu_r <= 10'(u_c * u_c);
          ui2_r <= {9'(u_c * i_r), 1'b0};
          ii_r <= 10'(i_r * i_r);
          for (int k = 0; k < 4; k++) begin
            cnum_r[k] <= cn_c[k][12:0];
          end
          ph_r <= '0;
          st_r <= S_MAC;
        end
        S_MAC: begin
          case (ph_r) inside
            [4'd0:4'd2]: px_r <= acc_new;
            [4'd3:4'd5]: py_r <= acc_new;
            [4'd6:4'd7]: tx_r <= acc_new;
            default: ty_r <= acc_new;
          endcase
          ph_r <= ph_r + 1'b1;
          if (ph_r == 4'd9) begin
            st_r <= S_ABS;
          end
        end
        S_ABS: begin
          ax_r <= tx_mag[TW-1:0];
          ay_r <= ty_mag[TW-1:0];
          if (tx_r == '0 && ty_r == '0) begin
            ox_r <= '0;
            oy_r <= '0;
            op_r <= OP_PX;
            st_r <= S_LOAD;
          end else begin
            st_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (|mxv[TW-1:24]) begin
            ax_r <= ax_r >> 1;
            ay_r <= ay_r >> 1;
          end else if (!mxv[23]) begin
            ax_r <= ax_r << 1;
            ay_r <= ay_r << 1;
          end else begin
            st_r <= S_SQ0;
          end
        end
        S_SQ0: begin
          sqx_r <= 50'(ax_r[23:0] * ax_r[23:0]);
          st_r <= S_SQ1;
        end
        S_SQ1: begin
          sqx_r <= sqx_r + 50'(ay_r[23:0] * ay_r[23:0]);
          sqr_r <= '0;
          sqb_r <= 50'(1) << 48;
          scnt_r <= 5'd24;
          st_r <= S_SQRT;
        end
        S_SQRT: begin
          if (sqx_r >= trial) begin
            sqx_r <= sqx_r - trial;
            sqr_r <= (sqr_r >> 1) + sqb_r;
          end else begin
            sqr_r <= sqr_r >> 1;
          end
          sqb_r <= sqb_r >> 2;
          scnt_r <= scnt_r - 1'b1;
          if (scnt_r == '0) begin
            op_r <= OP_MX;
            st_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          div_req_r.start <= 1'b1;
          case (op_r) inside
            OP_MX, OP_MY: begin
              div_req_r.dividend <= DVW'(((op_r == OP_MX) ? ay_r[23:0] : ax_r[23:0]) * wq)
                                  + DVW'(len >> 1);
              div_req_r.count <= CNT_W'(DVW);
              div_req_r.divisor <= len;
            end
            OP_PX, OP_PY: begin
              pneg_r <= pa[AW-1];
              div_req_r.dividend <= {pa_mag[43:0], 8'd0};
              div_req_r.count <= CNT_W'(44);
              div_req_r.divisor <= DSW'(d_r);
            end
            default: begin
              div_req_r.dividend <= {cnum_r[op_r[1:0]], 39'd0};
              div_req_r.count <= CNT_W'(13);
              div_req_r.divisor <= DSW'(n_r);
            end
          endcase
          st_r <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            st_r <= S_LOAD;
            unique case (op_r)
              OP_MX: begin
                ox_r <= ty_r[AW-1] ? OW'({1'b0, mq}) : -OW'({1'b0, mq});
                op_r <= OP_MY;
              end
              OP_MY: begin
                oy_r <= tx_r[AW-1] ? -OW'({1'b0, mq}) : OW'({1'b0, mq});
                op_r <= OP_PX;
              end
              OP_PX: begin
                qx_r <= qf;
                op_r <= OP_PY;
              end
              OP_PY: begin
                qy_r <= qf;
                op_r <= OP_C0;
              end
              OP_C0: begin
                col_r[0] <= div_rsp.quot[7:0];
                op_r <= OP_C1;
              end
              OP_C1: begin
                col_r[1] <= div_rsp.quot[7:0];
                op_r <= OP_C2;
              end
              OP_C2: begin
                col_r[2] <= div_rsp.quot[7:0];
                op_r <= OP_C3;
              end
              default: begin
                col_r[3] <= div_rsp.quot[7:0];
                st_r <= S_EMIT0;
              end
            endcase
          end
        end
        S_EMIT0: begin
          out_valid_r <= 1'b1;
          out_r.vertex_x <= sat16(v0x);
          out_r.vertex_y <= sat16(v0y);
          out_r.red <= col_r[0];
          out_r.green <= col_r[1];
          out_r.blue <= col_r[2];
          out_r.alpha <= col_r[3];
          out_r.step_index <= i_r;
          out_r.side <= 1'b0;
          out_r.last <= 1'b0;
          st_r <= S_EMIT1;
        end
        S_EMIT1: begin
          out_valid_r <= 1'b1;
          out_r.vertex_x <= sat16(v1x);
          out_r.vertex_y <= sat16(v1y);
          out_r.side <= 1'b1;
          out_r.last <= i_r == n_r;
          if (i_r == n_r) begin
            st_r <= S_IDLE;
          end else begin
            i_r <= i_r + 1'b1;
            st_r <= S_PREP;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign div_req = div_req_r;
  assign out_valid = out_valid_r;
  assign out_item = out_r;

endmodule

`default_nettype wire

[hdl/bezier_stroke_tessellator.sv]
// bezier_stroke_tessellator: top level, register file and block wiring
// depends on bst_pkg, bst_front, bst_queue, bst_div, bst_back
//
// One input transaction is a quadratic curve request (start point, end point,
// bend); it is taken at a clock edge with start high and busy low. The front
// stage holds the request while it forms the control point, then hands it to
// a two-entry job queue, so up to three requests can wait while the back
// stage works. The back stage walks n+1 steps, n being segment_count or 1 when
// it is zero, and emits two strip vertices per step on the out_ ports, each
// valid for exactly one cycle with out_valid; the receiver cannot stall.
// Per step the work runs through one shared restoring divider and a one-bit
// per cycle square root: the multiply-accumulate phases, normalization, the
// square root, two offset divisions, two point divisions and four color
// divisions. Registers must be written over the APB port only while the block
// is idle; the block itself does not enforce this. Synchronous reset empties the
// queue, idles both stages and restores the register reset values.
`default_nettype none

module bezier_stroke_tessellator import bst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  output out_item_t        out_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0] stroke_width_r;
  logic [SEG_W-1:0] segment_count_r;
  logic [31:0] start_color_r;
  logic [31:0] end_color_r;

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  job_t push_job;
  job_t pop_job;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stroke_width_r <= 16'd16;
      segment_count_r <= SEG_W'(16);
      start_color_r <= 32'hffff_ffff;
      end_color_r <= 32'hffff_ffff;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_STROKE_WIDTH: stroke_width_r <= pwdata[15:0];
        REG_SEGMENT_COUNT: segment_count_r <= pwdata[SEG_W-1:0];
        REG_START_COLOR: start_color_r <= pwdata;
        REG_END_COLOR: end_color_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_STROKE_WIDTH: prdata = {16'd0, stroke_width_r};
      REG_SEGMENT_COUNT: prdata = {{(32-SEG_W){1'b0}}, segment_count_r};
      REG_START_COLOR: prdata = start_color_r;
      REG_END_COLOR: prdata = end_color_r;
      default: prdata = '0;
    endcase
  end

  bst_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .item   (in_item),
    .busy   (busy),
    .q_full (q_full),
    .push   (q_push),
    .job    (push_job)
  );

  bst_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_job),
    .pop   (q_pop),
    .rdata (pop_job),
    .empty (q_empty),
    .full  (q_full)
  );

  bst_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  bst_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .stroke_width  (stroke_width_r),
    .segment_count (segment_count_r),
    .start_color   (start_color_r),
    .end_color     (end_color_r),
    .q_empty       (q_empty),
    .q_data        (pop_job),
    .q_pop         (q_pop),
    .div_req       (div_req),
    .div_rsp       (div_rsp),
    .out_valid     (out_valid),
    .out_item      (out_item)
  );

endmodule

`default_nettype wire
